// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the memo cache. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("memo cache assertion failed");

// Next-cycle implication.
`define HMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("memo cache assertion failed");

`endif

// ----- rtl/hmc_pkg.sv -----
package hmc_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int PROBE_SLOTS = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PRB_W       = $clog2(PROBE_SLOTS);

  localparam int KEY_W   = 64;
  localparam int SLOT_W  = 12;
  localparam int STAMP_W = 32;
  localparam int HCNT_W  = 16;
  localparam int TOT_W   = 32;

  localparam logic [63:0] HASH_MUL   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SIGN_CLEAR = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_STORE  = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YOUNG_AGE = 2'd1;

  localparam logic [HCNT_W-1:0]  HOT_THR_RST   = 16'd3;
  localparam logic [STAMP_W-1:0] YOUNG_AGE_RST = 32'd1000;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [KEY_W-1:0] key_c;
    logic [KEY_W-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [KEY_W-1:0]  value_out;
    logic [SLOT_W-1:0] slot_index;
    logic [TOT_W-1:0]  hit_total;
    logic [TOT_W-1:0]  miss_total;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [KEY_W-1:0] key_c;
    logic [KEY_W-1:0] value;
    logic [KEY_W-1:0] hash;
  } entry_data_t;

  typedef struct packed {
    logic               valid;
    logic [HCNT_W-1:0]  hit_count;
    logic [STAMP_W-1:0] stamp;
  } entry_meta_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_X1,
    ST_MUL_X2,
    ST_MIX_B,
    ST_MIX_C,
    ST_READ,
    ST_CHECK,
    ST_PRB_RD,
    ST_PRB_CK,
    ST_WRITE
  } state_t;

endpackage

// ----- rtl/hashed_memo_cache_engine_top.sv -----
// Memo cache keyed by three 64-bit words, one command word at a time.
// Input channel (in_valid, in_stall, in_word): a word is taken when in_valid is high
// and in_stall is low. in_stall is high whenever an earlier word is still in work.
// Result channel (out_valid, out_stall, out_word): exactly one result per command,
// held in an output register until the receiver takes it with out_stall low.
// Configuration (cfg_we, cfg_index, cfg_wdata): index 0 sets the hot hit threshold,
// index 1 the young age limit; other indexes are ignored. Write only while idle.
// From acceptance to result: the hash runs through ST_MUL_LO, ST_MUL_X1, ST_MUL_X2,
// ST_MIX_B and ST_MIX_C on one shared 32x32 multiplier and the mix adders, then one
// table read in ST_READ and a check in ST_CHECK. A lookup is ready from ST_CHECK,
// a plain store from ST_WRITE, and a store that probes neighbors passes ST_PRB_RD
// and ST_PRB_CK per probed slot before ST_WRITE, up to seven with eight probe slots.
// A new word is taken only back in ST_IDLE, after the result is loaded.
// After reset the entry status memory is swept one entry per cycle, all 4096 entries,
// while in_stall stays high; configuration writes are taken during the sweep.
// If the receiver stalls, the finished result waits in the output register and
// the block holds the next result, table update included, until it is free.
module hashed_memo_cache_engine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hmc_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hmc_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [hmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hmc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import hmc_pkg::*;

  `include "assert_macros.svh"

  state_t             state_r, state_nxt;
  in_word_t           item_r;
  logic [KEY_W-1:0]   h_r, h_nxt;
  logic [KEY_W-1:0]   kbm_r, kbm_nxt;
  logic [KEY_W-1:0]   kcm_r, kcm_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [STAMP_W-1:0] age_r, age_nxt;
  logic [PRB_W-1:0]   probe_i_r, probe_i_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [STAMP_W-1:0] stamp_clk_r, stamp_nxt;
  logic [TOT_W-1:0]   hit_cnt_r, hit_nxt;
  logic [TOT_W-1:0]   miss_cnt_r, miss_nxt;
  logic [HCNT_W-1:0]  hot_thr_r;
  logic [STAMP_W-1:0] young_lim_r;
  out_word_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  entry_data_t        data_mem [TABLE_DEPTH];
  entry_meta_t        meta_mem [TABLE_DEPTH];
  entry_data_t        data_q_r;
  entry_meta_t        meta_q_r;
  logic               data_we, data_re, meta_we, meta_re;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  entry_data_t        data_wd;
  entry_meta_t        meta_wd;

  logic               in_accept, emit, out_free, is_store;
  logic [KEY_W-1:0]   key_a_m, key_c_m;
  logic [31:0]        mul_x, mul_y;
  logic [63:0]        mul_p;
  logic [KEY_W-1:0]   mix_in, mix_val;
  logic [IDX_W-1:0]   home, probe_addr, slot_off;
  logic               lookup_hit, protect, alt_free, probe_last;
  logic [STAMP_W-1:0] home_age, alt_age, stamp_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_store  = (item_r.command == CMD_STORE);

  assign key_a_m = item_r.key_a & SIGN_CLEAR;
  assign key_c_m = item_r.key_c & SIGN_CLEAR;

  // Low 64 bits of the key product, built from three 32x32 partial products.
  always_comb begin
    case (state_r)
      ST_MUL_LO: begin
        mul_x = key_a_m[31:0];
        mul_y = HASH_MUL[31:0];
      end
      ST_MUL_X1: begin
        mul_x = key_a_m[31:0];
        mul_y = HASH_MUL[63:32];
      end
      default: begin
        mul_x = key_a_m[63:32];
        mul_y = HASH_MUL[31:0];
      end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  assign mix_in  = (state_r == ST_MIX_B) ? kbm_r : kcm_r;
  assign mix_val = h_r ^ (mix_in + (h_r << 6) + (h_r >> 2));

  assign home       = h_r[IDX_W-1:0];
  assign probe_addr = home + IDX_W'(probe_i_r);
  assign probe_last = (probe_i_r == PRB_W'(PROBE_SLOTS - 1));
  assign slot_off   = slot_r - home;
  assign stamp_inc  = stamp_clk_r + 1'b1;

  assign lookup_hit = meta_q_r.valid && (data_q_r.hash == h_r) &&
                      (data_q_r.key_a == item_r.key_a) &&
                      (data_q_r.key_b == item_r.key_b) &&
                      (data_q_r.key_c == item_r.key_c);
  assign home_age = stamp_clk_r - meta_q_r.stamp;
  assign protect  = meta_q_r.valid && (meta_q_r.hit_count > hot_thr_r) &&
                    (home_age < young_lim_r);
  assign alt_age  = stamp_clk_r - meta_q_r.stamp;
  assign alt_free = !meta_q_r.valid || (alt_age > age_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_idx_r == IDX_W'(TABLE_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_X1;
      ST_MUL_X1: state_nxt = ST_MUL_X2;
      ST_MUL_X2: state_nxt = ST_MIX_B;
      ST_MIX_B:  state_nxt = ST_MIX_C;
      ST_MIX_C:  state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (is_store) begin
          state_nxt = protect ? ST_PRB_RD : ST_WRITE;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PRB_RD: state_nxt = ST_PRB_CK;
      ST_PRB_CK: state_nxt = (alt_free || probe_last) ? ST_WRITE : ST_PRB_RD;
      ST_WRITE:  if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    h_nxt       = h_r;
    kbm_nxt     = kbm_r;
    kcm_nxt     = kcm_r;
    slot_nxt    = slot_r;
    age_nxt     = age_r;
    probe_i_nxt = probe_i_r;
    clr_idx_nxt = clr_idx_r;
    stamp_nxt   = stamp_clk_r;
    hit_nxt     = hit_cnt_r;
    miss_nxt    = miss_cnt_r;
    out_nxt     = out_r;
    emit        = 1'b0;
    data_we     = 1'b0;
    data_re     = 1'b0;
    meta_we     = 1'b0;
    meta_re     = 1'b0;
    rd_addr     = home;
    wr_addr     = home;
    meta_wd     = '0;
    data_wd     = '{key_a: item_r.key_a, key_b: item_r.key_b, key_c: item_r.key_c,
                    value: item_r.value_in, hash: h_r};
    case (state_r)
      ST_CLEAR: begin
        meta_we     = 1'b1;
        wr_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ST_MUL_LO: h_nxt = mul_p;
      ST_MUL_X1: begin
        h_nxt   = {h_r[63:32] + mul_p[31:0], h_r[31:0]};
        kbm_nxt = item_r.key_b + HASH_MUL;
      end
      ST_MUL_X2: begin
        h_nxt   = {h_r[63:32] + mul_p[31:0], h_r[31:0]};
        kcm_nxt = key_c_m + HASH_MUL;
      end
      ST_MIX_B, ST_MIX_C: h_nxt = mix_val;
      ST_READ: begin
        data_re = 1'b1;
        meta_re = 1'b1;
      end
      ST_CHECK: begin
        if (is_store) begin
          if (protect) begin
            age_nxt     = home_age;
            probe_i_nxt = PRB_W'(1);
          end else begin
            slot_nxt = home;
          end
        end else if (out_free) begin
          emit = 1'b1;
          out_nxt.hit        = lookup_hit;
          out_nxt.value_out  = lookup_hit ? data_q_r.value : '0;
          out_nxt.slot_index = SLOT_W'(home);
          if (lookup_hit) begin
            meta_we   = 1'b1;
            meta_wd   = '{valid: 1'b1, hit_count: meta_q_r.hit_count + 1'b1,
                          stamp: stamp_inc};
            stamp_nxt = stamp_inc;
            hit_nxt   = hit_cnt_r + 1'b1;
          end else begin
            miss_nxt = miss_cnt_r + 1'b1;
          end
          out_nxt.hit_total  = lookup_hit ? hit_cnt_r + 1'b1 : hit_cnt_r;
          out_nxt.miss_total = lookup_hit ? miss_cnt_r : miss_cnt_r + 1'b1;
        end
      end
      ST_PRB_RD: begin
        meta_re = 1'b1;
        rd_addr = probe_addr;
      end
      ST_PRB_CK: begin
        if (alt_free) begin
          slot_nxt = probe_addr;
        end else if (probe_last) begin
          slot_nxt = home;
        end else begin
          probe_i_nxt = probe_i_r + 1'b1;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          emit      = 1'b1;
          data_we   = 1'b1;
          meta_we   = 1'b1;
          wr_addr   = slot_r;
          meta_wd   = '{valid: 1'b1, hit_count: '0, stamp: stamp_inc};
          stamp_nxt = stamp_inc;
          out_nxt   = '{hit: 1'b0, value_out: '0, slot_index: SLOT_W'(slot_r),
                        hit_total: hit_cnt_r, miss_total: miss_cnt_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[wr_addr] <= data_wd;
    end
    if (data_re) begin
      data_q_r <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[wr_addr] <= meta_wd;
    end
    if (meta_re) begin
      meta_q_r <= meta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      stamp_clk_r <= STAMP_W'(1);
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      hot_thr_r   <= HOT_THR_RST;
      young_lim_r <= YOUNG_AGE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      stamp_clk_r <= stamp_nxt;
      hit_cnt_r   <= hit_nxt;
      miss_cnt_r  <= miss_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == CFG_HOT_THR)) begin
        hot_thr_r <= cfg_wdata[HCNT_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_YOUNG_AGE)) begin
        young_lim_r <= cfg_wdata[STAMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_word;
    end
    h_r       <= h_nxt;
    kbm_r     <= kbm_nxt;
    kcm_r     <= kcm_nxt;
    slot_r    <= slot_nxt;
    age_r     <= age_nxt;
    probe_i_r <= probe_i_nxt;
    out_r     <= out_nxt;
  end

  // A store never lands outside the probe window of its home slot.
  `HMC_ASSERT_IMP(a_slot_window, data_we, {1'b0, slot_off} < (IDX_W + 1)'(PROBE_SLOTS))
  // Every entry write also refreshes that entry's status word.
  `HMC_ASSERT_IMP(a_data_with_meta, data_we, meta_we && (wr_addr == slot_r))
  // The stamp clock moves by exactly one on each hit and each store.
  `HMC_ASSERT_NXT(a_stamp_step, meta_we && (state_r != ST_CLEAR),
                  stamp_clk_r == $past(stamp_clk_r) + 32'd1)
  // A lookup bumps exactly one of the two running totals.
  `HMC_ASSERT_NXT(a_one_total, emit && !is_store,
                  (hit_cnt_r - $past(hit_cnt_r)) + (miss_cnt_r - $past(miss_cnt_r)) == 32'd1)

endmodule
